// ===== hw/rtl/nmea_chk_pkg.sv =====
// ----------------------------------------------------------------------------
// nmea_chk_pkg
// Shared constants, types and helper functions for the NMEA sentence checker.
// ----------------------------------------------------------------------------
package nmea_chk_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [4:0] HEX_NONE  = 5'd16;
    localparam logic [2:0] ADDR_LEN  = 3'd5;

    localparam logic [1:0] KIND_GGA   = 2'd0;
    localparam logic [1:0] KIND_RMC   = 2'd1;
    localparam logic [1:0] KIND_OTHER = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    typedef struct packed {
        logic       done;
        logic [1:0] kind;
        logic [7:0] computed;
        logic [7:0] received;
    } result_t;

    // Digit value 0..15, or HEX_NONE for a byte that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= 8'h30 && c <= 8'h39) begin
                d = c - 8'h30;
            end else if (c >= 8'h41 && c <= 8'h46) begin
                d = c - 8'h37;
            end else if (c >= 8'h61 && c <= 8'h66) begin
                d = c - 8'h57;
            end else begin
                d = {3'd0, HEX_NONE};
            end
            return d[4:0];
        end
    endfunction

    // Expected address characters "GPGGA" and "GPRMC".
    function automatic logic [7:0] gga_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            unique case (pos)
                3'd0:    c = 8'h47;
                3'd1:    c = 8'h50;
                3'd2:    c = 8'h47;
                3'd3:    c = 8'h47;
                3'd4:    c = 8'h41;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    function automatic logic [7:0] rmc_char(input logic [2:0] pos);
        logic [7:0] c;
        begin
            unique case (pos)
                3'd0:    c = 8'h47;
                3'd1:    c = 8'h50;
                3'd2:    c = 8'h52;
                3'd3:    c = 8'h4D;
                3'd4:    c = 8'h43;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== hw/rtl/nmea_chk_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_chk_parser
// Sentence parse state: running XOR, received checksum digits, address match
// and the classification produced on carriage return.
// ----------------------------------------------------------------------------
module nmea_chk_parser (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step_en,
    input  logic [7:0]              rx_byte,
    output nmea_chk_pkg::result_t   res
);

    logic       in_sentence_reg, in_sentence_next;
    logic       past_star_reg,   past_star_next;
    logic       hex_active_reg,  hex_active_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic [7:0] sum_field_reg,   sum_field_next;
    logic [2:0] header_pos_reg,  header_pos_next;
    logic       gga_match_reg,   gga_match_next;
    logic       rmc_match_reg,   rmc_match_next;

    logic [4:0] digit;

    assign digit = nmea_chk_pkg::hex_value(rx_byte);

    always_comb begin
        in_sentence_next = in_sentence_reg;
        past_star_next   = past_star_reg;
        hex_active_next  = hex_active_reg;
        running_xor_next = running_xor_reg;
        sum_field_next   = sum_field_reg;
        header_pos_next  = header_pos_reg;
        gga_match_next   = gga_match_reg;
        rmc_match_next   = rmc_match_reg;

        res.done     = 1'b0;
        res.kind     = nmea_chk_pkg::KIND_OTHER;
        res.computed = running_xor_reg;
        res.received = sum_field_reg;

        if (rx_byte == nmea_chk_pkg::CH_DOLLAR) begin
            in_sentence_next = 1'b1;
            past_star_next   = 1'b0;
            hex_active_next  = 1'b0;
            running_xor_next = 8'd0;
            sum_field_next   = 8'd0;
            header_pos_next  = 3'd0;
            gga_match_next   = 1'b1;
            rmc_match_next   = 1'b1;
        end else if (in_sentence_reg) begin
            if (rx_byte == nmea_chk_pkg::CH_CR) begin
                res.done = step_en;
                if (!past_star_reg || running_xor_reg != sum_field_reg) begin
                    res.kind = nmea_chk_pkg::KIND_ERROR;
                end else if (header_pos_reg == nmea_chk_pkg::ADDR_LEN && gga_match_reg) begin
                    res.kind = nmea_chk_pkg::KIND_GGA;
                end else if (header_pos_reg == nmea_chk_pkg::ADDR_LEN && rmc_match_reg) begin
                    res.kind = nmea_chk_pkg::KIND_RMC;
                end else begin
                    res.kind = nmea_chk_pkg::KIND_OTHER;
                end
                in_sentence_next = 1'b0;
                hex_active_next  = 1'b0;
            end else if (!past_star_reg) begin
                if (rx_byte == nmea_chk_pkg::CH_STAR) begin
                    past_star_next  = 1'b1;
                    hex_active_next = 1'b1;
                end else begin
                    running_xor_next = running_xor_reg ^ rx_byte;
                    if (header_pos_reg < nmea_chk_pkg::ADDR_LEN) begin
                        if (rx_byte != nmea_chk_pkg::gga_char(header_pos_reg)) begin
                            gga_match_next = 1'b0;
                        end
                        if (rx_byte != nmea_chk_pkg::rmc_char(header_pos_reg)) begin
                            rmc_match_next = 1'b0;
                        end
                        header_pos_next = header_pos_reg + 3'd1;
                    end
                end
            end else if (hex_active_reg) begin
                if (digit != nmea_chk_pkg::HEX_NONE) begin
                    sum_field_next = {sum_field_reg[3:0], digit[3:0]};
                end else begin
                    hex_active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg <= 1'b0;
            past_star_reg   <= 1'b0;
            hex_active_reg  <= 1'b0;
            running_xor_reg <= 8'd0;
            sum_field_reg   <= 8'd0;
            header_pos_reg  <= 3'd0;
            gga_match_reg   <= 1'b0;
            rmc_match_reg   <= 1'b0;
        end else if (step_en) begin
            in_sentence_reg <= in_sentence_next;
            past_star_reg   <= past_star_next;
            hex_active_reg  <= hex_active_next;
            running_xor_reg <= running_xor_next;
            sum_field_reg   <= sum_field_next;
            header_pos_reg  <= header_pos_next;
            gga_match_reg   <= gga_match_next;
            rmc_match_reg   <= rmc_match_next;
        end
    end

endmodule

// ===== hw/rtl/nmea_sentence_checker_core.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_checker_core
// Checks NMEA 0183 sentences byte by byte and reports one result per sentence.
// ----------------------------------------------------------------------------
// A result is registered on m_ when its carriage return leaves the input register.
// The block takes one byte per cycle while no result is left waiting on m_.
// A result left waiting on m_ holds the byte in the input register, and s_ready
// then follows m_ready.
// Reset (aresetn low, synchronous) clears all parse state and empties both
// registers; the block accepts bytes on the cycle after reset is released.
module nmea_sentence_checker_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_sentence_kind,
    output logic [7:0] m_computed_sum,
    output logic [7:0] m_received_sum
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [7:0] computed_reg;
    logic [7:0] received_reg;
    logic       advance;

    nmea_chk_pkg::result_t res;

    // The buffered item moves through the parser only when the result
    // register is free or is being emptied this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    nmea_chk_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .rx_byte (in_byte_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res.done) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.done) begin
            kind_reg     <= res.kind;
            computed_reg <= res.computed;
            received_reg <= res.received;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_sentence_kind = kind_reg;
    assign m_computed_sum  = computed_reg;
    assign m_received_sum  = received_reg;

endmodule
